// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL files that check their own control logic.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");

`else

`define ASSERT_NEVER(lbl, clk, rst, cond)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/ghe_pkg.sv =====
`timescale 1ns / 1ps

package ghe_pkg;

  // Field widths.
  localparam int Q_W   = 16;
  localparam int POS_W = 24;
  localparam int ANG_W = 16;
  localparam int ERR_W = 17;

  // CORDIC datapath: 44 bits hold the prescaled operands with gain headroom.
  localparam int CW = 44;
  // Angle accumulator at 2^-24 rad.
  localparam int ZW = 28;
  localparam int ATAN_LEN = 24;
  localparam int DEF_CORDIC_STEPS = 16;
  localparam int ROUND_SH = 11;

  localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [ZW-1:0] ROUND_HALF  = 28'sd1024;

  // Yaw operands: 2*(..) at 2^-28, then times 2^8, so a shift of 9 in total.
  localparam int YAW_SH = 9;
  // The constant 1.0 at 2^-28, times 2^8.
  localparam logic signed [CW-1:0] YAW_ONE = 44'sh010_0000_0000;
  // Bearing operands are scaled by 2^16.
  localparam int BRG_SH = 16;

  // Accepted-but-not-dispatched credit limit and the operand queue depth.
  localparam int FRONT_CAP   = 4;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic {
    REG_TARGET_X = 1'b0,
    REG_TARGET_Y = 1'b1
  } reg_idx_t;

  // Operand pairs for the two atan2 evaluations.
  typedef struct packed {
    logic signed [CW-1:0] yaw_y;
    logic signed [CW-1:0] yaw_x;
    logic signed [CW-1:0] brg_y;
    logic signed [CW-1:0] brg_x;
  } ops_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] heading_error;
    logic signed [ANG_W-1:0] yaw_angle;
    logic signed [ANG_W-1:0] bearing_angle;
  } res_t;

  // atan(2^-i) at 2^-24 rad, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_q24(input int i);
    case (i)
      0:  return 28'sd13176795;
      1:  return 28'sd7778716;
      2:  return 28'sd4110060;
      3:  return 28'sd2086331;
      4:  return 28'sd1047214;
      5:  return 28'sd524117;
      6:  return 28'sd262123;
      7:  return 28'sd131069;
      8:  return 28'sd65536;
      9:  return 28'sd32768;
      10: return 28'sd16384;
      11: return 28'sd8192;
      12: return 28'sd4096;
      13: return 28'sd2048;
      14: return 28'sd1024;
      15: return 28'sd512;
      16: return 28'sd256;
      17: return 28'sd128;
      18: return 28'sd64;
      19: return 28'sd32;
      20: return 28'sd16;
      21: return 28'sd8;
      22: return 28'sd4;
      23: return 28'sd2;
      default: return '0;
    endcase
  endfunction

endpackage

// ===== rtl/ghe_fifo.sv =====
`timescale 1ns / 1ps

// Small register FIFO. DEPTH must be a power of two.
module ghe_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic             full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [AW:0]      wr_ptr;
  logic [AW:0]      rd_ptr;
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr[AW-1:0]] <= push_data;
    end
  end

  assign pop_data = mem[rd_ptr[AW-1:0]];
  assign empty    = (wr_ptr == rd_ptr);
  assign full     = (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]) && (wr_ptr[AW] != rd_ptr[AW]);

endmodule

// ===== rtl/ghe_front.sv =====
`timescale 1ns / 1ps

// Front end: forms the atan2 operands of a pose in two register stages.
module ghe_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              take,
  input  logic signed [ghe_pkg::Q_W-1:0]    quat_w,
  input  logic signed [ghe_pkg::Q_W-1:0]    quat_x,
  input  logic signed [ghe_pkg::Q_W-1:0]    quat_y,
  input  logic signed [ghe_pkg::Q_W-1:0]    quat_z,
  input  logic signed [ghe_pkg::POS_W-1:0]  pos_x,
  input  logic signed [ghe_pkg::POS_W-1:0]  pos_y,
  input  logic signed [ghe_pkg::POS_W-1:0]  target_x,
  input  logic signed [ghe_pkg::POS_W-1:0]  target_y,
  output logic                              push,
  output ghe_pkg::ops_t                     ops
);

  import ghe_pkg::*;

  localparam int PW = 2 * Q_W;
  localparam int DW = POS_W + 1;

  logic                 v1;
  logic signed [PW-1:0] p_wz;
  logic signed [PW-1:0] p_xy;
  logic signed [PW-1:0] p_yy;
  logic signed [PW-1:0] p_zz;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [CW-1:0] s_sum;
  logic signed [CW-1:0] q_sum;

  // Stage one: the four products and the position differences.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= take;
    end
    p_wz <= PW'(quat_w) * PW'(quat_z);
    p_xy <= PW'(quat_x) * PW'(quat_y);
    p_yy <= PW'(quat_y) * PW'(quat_y);
    p_zz <= PW'(quat_z) * PW'(quat_z);
    dx   <= DW'(target_x) - DW'(pos_x);
    dy   <= DW'(pos_y) - DW'(target_y);
  end

  always_comb begin
    s_sum = CW'(p_wz) + CW'(p_xy);
    q_sum = CW'(p_yy) + CW'(p_zz);
  end

  // Stage two: scale to the common CORDIC format.
  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= v1;
    end
    ops.yaw_y <= s_sum <<< YAW_SH;
    ops.yaw_x <= YAW_ONE - (q_sum <<< YAW_SH);
    ops.brg_y <= CW'(dy) <<< BRG_SH;
    ops.brg_x <= CW'(dx) <<< BRG_SH;
  end

endmodule

// ===== rtl/ghe_cordic.sv =====
`timescale 1ns / 1ps

// Pipelined vectoring CORDIC atan2, one iteration per stage.
module ghe_cordic #(
  parameter int STEPS = ghe_pkg::DEF_CORDIC_STEPS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic signed [ghe_pkg::CW-1:0]    in_y,
  input  logic signed [ghe_pkg::CW-1:0]    in_x,
  output logic                             out_valid,
  output logic signed [ghe_pkg::ANG_W-1:0] angle
);

  import ghe_pkg::*;

  logic [STEPS:0]       vld;
  logic [STEPS:0]       zf;
  logic signed [CW-1:0] xs [STEPS+1];
  logic signed [CW-1:0] ys [STEPS+1];
  logic signed [ZW-1:0] zs [STEPS+1];
  logic signed [ZW-1:0] zr;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      vld       <= {vld[STEPS-1:0], in_valid};
      out_valid <= vld[STEPS];
    end

    // Rotate a left half-plane vector by a quarter turn first.
    zf[0] <= (in_x == '0) && (in_y == '0);
    if (in_x < 0) begin
      if (in_y >= 0) begin
        xs[0] <= in_y;
        ys[0] <= -in_x;
        zs[0] <= HALF_PI_Q24;
      end else begin
        xs[0] <= -in_y;
        ys[0] <= in_x;
        zs[0] <= -HALF_PI_Q24;
      end
    end else begin
      xs[0] <= in_x;
      ys[0] <= in_y;
      zs[0] <= '0;
    end

    for (int i = 0; i < STEPS; i++) begin
      zf[i+1] <= zf[i];
      if (!ys[i][CW-1]) begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + atan_q24(i);
      end else begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - atan_q24(i);
      end
    end

    angle <= zf[STEPS] ? '0 : zr[ROUND_SH+ANG_W-1:ROUND_SH];
  end

  assign zr = zs[STEPS] + ROUND_HALF;

endmodule

// ===== rtl/ghe_back.sv =====
`timescale 1ns / 1ps

// Back end: both atan2 pipelines, the difference and the result FIFO.
// Dispatch is credit based, so the pipelines never stall.
module ghe_back #(
  parameter int STEPS = ghe_pkg::DEF_CORDIC_STEPS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             take,
  input  ghe_pkg::ops_t                    ops,
  output logic                             ready,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [ghe_pkg::ERR_W-1:0] heading_error,
  output logic signed [ghe_pkg::ANG_W-1:0] yaw_angle,
  output logic signed [ghe_pkg::ANG_W-1:0] bearing_angle
);

  import ghe_pkg::*;

  localparam int OUT_DEPTH = 1 << $clog2(STEPS + 5);
  localparam int BCW       = $clog2(OUT_DEPTH + 1);

  logic                    yaw_v;
  logic                    brg_v;
  logic signed [ANG_W-1:0] yaw;
  logic signed [ANG_W-1:0] brg;
  res_t                    res_in;
  res_t                    res_out;
  logic                    deliver;
  logic                    f_empty;
  logic                    f_full;
  logic [BCW-1:0]          bcnt;
  logic [BCW-1:0]          bcnt_next;

  ghe_cordic #(.STEPS(STEPS)) u_yaw (
    .clk      (clk),
    .rst      (rst),
    .in_valid (take),
    .in_y     (ops.yaw_y),
    .in_x     (ops.yaw_x),
    .out_valid(yaw_v),
    .angle    (yaw)
  );

  ghe_cordic #(.STEPS(STEPS)) u_brg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (take),
    .in_y     (ops.brg_y),
    .in_x     (ops.brg_x),
    .out_valid(brg_v),
    .angle    (brg)
  );

  always_comb begin
    res_in.heading_error = ERR_W'(yaw) - ERR_W'(brg);
    res_in.yaw_angle     = yaw;
    res_in.bearing_angle = brg;
  end

  ghe_fifo #(.DEPTH(OUT_DEPTH), .WIDTH($bits(res_t))) u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (yaw_v && brg_v),
    .push_data(res_in),
    .pop      (deliver),
    .pop_data (res_out),
    .empty    (f_empty),
    .full     (f_full)
  );

  // Every dispatched item holds a FIFO slot until it is delivered.
  assign bcnt_next = bcnt + BCW'(take) - BCW'(deliver);

  always_ff @(posedge clk) begin
    if (rst) begin
      bcnt <= '0;
    end else begin
      bcnt <= bcnt_next;
    end
  end

  assign ready         = (bcnt < BCW'(OUT_DEPTH)) && !f_full;
  assign out_valid     = !f_empty;
  assign deliver       = out_valid && out_ready;
  assign heading_error = res_out.heading_error;
  assign yaw_angle     = res_out.yaw_angle;
  assign bearing_angle = res_out.bearing_angle;

endmodule

// ===== rtl/goal_heading_error_core.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Heading error of a robot toward a programmed goal.
// Configuration: write target_x (index 0) and target_y (index 1) through cfg_we,
// cfg_index and cfg_data while the block is idle; both reset to zero.
// Input channel (in_valid/in_ready): one pose request carries a Q1.14 quaternion
// and an x,y position. Output channel (out_valid/out_ready): one result request
// per pose with yaw, bearing and their unwrapped difference, in units of 2^-13 rad.
// From acceptance, a pose passes through the two operand stages, the operand queue,
// the two CORDIC pipelines (one stage per iteration) and the result FIFO. One pose
// is accepted every cycle as long as the receiver keeps up.
// Reset clears all valid bits, pointers and credit counters; no request is in
// flight afterwards. When the receiver stalls, results collect in the result
// FIFO (a power of two of at least min(CORDIC_STEPS, 24) + 5 entries), then dispatch
// stops, the operand queue fills, and in_ready drops. Nothing is lost or repeated.
module goal_heading_error_core #(
  parameter int CORDIC_STEPS = ghe_pkg::DEF_CORDIC_STEPS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [ghe_pkg::POS_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [ghe_pkg::Q_W-1:0]   quat_w,
  input  logic signed [ghe_pkg::Q_W-1:0]   quat_x,
  input  logic signed [ghe_pkg::Q_W-1:0]   quat_y,
  input  logic signed [ghe_pkg::Q_W-1:0]   quat_z,
  input  logic signed [ghe_pkg::POS_W-1:0] pos_x,
  input  logic signed [ghe_pkg::POS_W-1:0] pos_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [ghe_pkg::ERR_W-1:0] heading_error,
  output logic signed [ghe_pkg::ANG_W-1:0] yaw_angle,
  output logic signed [ghe_pkg::ANG_W-1:0] bearing_angle
);

  import ghe_pkg::*;

  // The arctangent table has 24 entries; more steps would add nothing.
  localparam int NS  = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int FCW = $clog2(FRONT_CAP + 1);

  logic signed [POS_W-1:0] target_x;
  logic signed [POS_W-1:0] target_y;
  logic                    take;
  logic                    q_push;
  ops_t                    f_ops;
  ops_t                    q_ops;
  logic                    q_empty;
  logic                    q_full;
  logic                    q_pop;
  logic                    back_ready;
  logic [FCW-1:0]          fcnt;
  logic [FCW-1:0]          fcnt_next;

  // Goal registers; the user must ensure configuration changes only while no request is in flight (unchecked).
  always_ff @(posedge clk) begin
    if (rst) begin
      target_x <= '0;
      target_y <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_TARGET_X) begin
        target_x <= cfg_data;
      end
      if (cfg_index == REG_TARGET_Y) begin
        target_y <= cfg_data;
      end
    end
  end

  // The front end counts requests it has accepted but not yet handed to the
  // back end. The queue holds at least that many, so it can never overflow,
  // and in_ready comes straight from a register compare.
  assign take      = in_valid && in_ready;
  assign fcnt_next = fcnt + FCW'(take) - FCW'(q_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      fcnt     <= '0;
      in_ready <= 1'b1;
    end else begin
      fcnt     <= fcnt_next;
      in_ready <= (fcnt_next < FCW'(FRONT_CAP));
    end
  end

  ghe_front u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .quat_w  (quat_w),
    .quat_x  (quat_x),
    .quat_y  (quat_y),
    .quat_z  (quat_z),
    .pos_x   (pos_x),
    .pos_y   (pos_y),
    .target_x(target_x),
    .target_y(target_y),
    .push    (q_push),
    .ops     (f_ops)
  );

  // Operand queue between the front and back ends.
  ghe_fifo #(.DEPTH(QUEUE_DEPTH), .WIDTH($bits(ops_t))) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(f_ops),
    .pop      (q_pop),
    .pop_data (q_ops),
    .empty    (q_empty),
    .full     (q_full)
  );

  assign q_pop = !q_empty && back_ready;

  ghe_back #(.STEPS(NS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .take         (q_pop),
    .ops          (q_ops),
    .ready        (back_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .heading_error(heading_error),
    .yaw_angle    (yaw_angle),
    .bearing_angle(bearing_angle)
  );

  // The queue must never be written while full.
  `ASSERT_NEVER(a_queue_overflow, clk, rst, q_push && q_full)
  // The front credit count stays within its limit.
  `ASSERT_NEVER(a_front_credit, clk, rst, fcnt > FCW'(FRONT_CAP))
  // With no accepted request outstanding the queue must be empty.
  `ASSERT_IMPLY(a_queue_drained, clk, rst, fcnt == '0, q_empty)
  // in_ready always agrees with the credit count.
  `ASSERT_IMPLY(a_ready_credit, clk, rst, !in_ready, fcnt == FCW'(FRONT_CAP))

endmodule
